FILE: hdl/wmd5_pkg.sv
// shared types, constants and round helpers for the whitened md5 compression block
`timescale 1ns / 1ps

package wmd5_pkg;

	localparam int WORDS_PER_BLOCK = 16;
	localparam int WORD_IDX_W      = $clog2(WORDS_PER_BLOCK);
	localparam int ROUNDS          = 64;
	localparam int ROUND_W         = $clog2(ROUNDS);

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic [31:0] message_word;
		logic        last_word;
	} wmd5_req_t;

	typedef struct packed {
		logic [63:0] digest_low;
		logic [63:0] digest_high;
	} wmd5_res_t;

	// md5 iv with the whitening constants folded in
	localparam word_t INIT_A = 32'h67452301 ^ 32'hEDEDEDED;
	localparam word_t INIT_B = 32'hefcdab89 ^ 32'hFEFEFEFE;
	localparam word_t INIT_C = 32'h98badcfe ^ 32'hCECECECE;
	localparam word_t INIT_D = 32'h10325476 ^ 32'hEEEEEEEE;

	localparam word_t KEYX_1 = 32'hABCDEF98;
	localparam word_t KEYX_2 = 32'h89DCBAFE;
	localparam word_t KEYX_3 = 32'hCB89EDFA;

	localparam logic [1:0] REG_KEY_MODE = 2'd0;

	localparam word_t STEP_ADD [ROUNDS] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	function automatic logic [4:0] rot_amount(input logic [1:0] grp, input logic [1:0] pos);
		logic [4:0] n;
		case ({grp, pos})
			4'h0:    n = 5'd7;
			4'h1:    n = 5'd12;
			4'h2:    n = 5'd17;
			4'h3:    n = 5'd22;
			4'h4:    n = 5'd5;
			4'h5:    n = 5'd9;
			4'h6:    n = 5'd14;
			4'h7:    n = 5'd20;
			4'h8:    n = 5'd4;
			4'h9:    n = 5'd11;
			4'hA:    n = 5'd16;
			4'hB:    n = 5'd23;
			4'hC:    n = 5'd6;
			4'hD:    n = 5'd10;
			4'hE:    n = 5'd15;
			default: n = 5'd21;
		endcase
		return n;
	endfunction

	// cumulative key xor for each group of sixteen rounds
	function automatic word_t key_xor(input logic [1:0] grp);
		word_t k;
		case (grp)
			2'd0:    k = '0;
			2'd1:    k = KEYX_1;
			2'd2:    k = KEYX_1 ^ KEYX_2;
			default: k = KEYX_1 ^ KEYX_2 ^ KEYX_3;
		endcase
		return k;
	endfunction

	function automatic word_t rotl(input word_t x, input logic [4:0] n);
		return (x << n) | (x >> (6'd32 - {1'b0, n}));
	endfunction

endpackage

FILE: hdl/whitened_md5_compression_top.sv
// whitened md5 compression block: word buffer, round sequencer and apb register
`timescale 1ns / 1ps

// a word that does not close a block is stored in the word buffer and busy stays low
// a word that fills a block or is marked last holds busy high during:
// 64 rounds through the one shared round unit, then the chain add
// a last word gives a one-cycle done strobe after the chain add that ends its block
// reset clears the sequencer, key_mode and word count and loads the whitened iv

module whitened_md5_compression_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  wmd5_pkg::wmd5_req_t  command,
	output logic                 done,
	output wmd5_pkg::wmd5_res_t  result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_FINAL = 2'd2;

	localparam int IW = wmd5_pkg::WORD_IDX_W;
	localparam int RW = wmd5_pkg::ROUND_W;

	logic [1:0]              state_q;
	logic [RW-1:0]           round_q;
	logic [IW-1:0]           count_q;
	logic [IW:0]             fill_q;
	logic                    last_q;
	logic                    key_mode_q;
	wmd5_pkg::word_t         word_buf_q [wmd5_pkg::WORDS_PER_BLOCK];
	wmd5_pkg::word_t         chain_q [4];
	wmd5_pkg::word_t         a_q, b_q, c_q, d_q;
	logic                    done_q;
	wmd5_pkg::wmd5_res_t     result_q;

	logic                    accept;
	logic                    block_end;
	logic                    cfg_write;
	logic [1:0]              grp;
	logic [IW-1:0]           s4;
	logic [IW-1:0]           idx;
	wmd5_pkg::word_t         f, w, sum, new_b;
	wmd5_pkg::word_t         fin_a, fin_b, fin_c, fin_d;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign block_end = command.last_word || (count_q == IW'(wmd5_pkg::WORDS_PER_BLOCK - 1));
	assign done      = done_q;
	assign result    = result_q;
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == wmd5_pkg::REG_KEY_MODE[0]);

	always_comb begin
		prdata = '0;
		if (paddr[2] == wmd5_pkg::REG_KEY_MODE[0]) begin
			prdata[0] = key_mode_q;
		end
	end

	// message schedule index for the current round
	assign grp = round_q[RW-1:RW-2];
	assign s4  = round_q[IW-1:0];

	always_comb begin
		case (grp)
			2'd0:    idx = s4;
			2'd1:    idx = s4 + {s4[1:0], 2'b00} + IW'(1);
			2'd2:    idx = s4 + {s4[2:0], 1'b0} + IW'(5);
			default: idx = {s4[0], 3'b000} - s4;
		endcase
	end

	always_comb begin
		case (grp)
			2'd0:    f = (b_q & c_q) | (~b_q & d_q);
			2'd1:    f = (b_q & d_q) | (c_q & ~d_q);
			2'd2:    f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
	end

	// words past the fill point of a final partial block read as zero before the key xor
	always_comb begin
		w = ({1'b0, idx} < fill_q) ? word_buf_q[idx] : '0;
		if (key_mode_q) begin
			w = w ^ wmd5_pkg::key_xor(grp);
		end
	end

	assign sum   = a_q + f + w + wmd5_pkg::STEP_ADD[round_q];
	assign new_b = b_q + wmd5_pkg::rotl(sum, wmd5_pkg::rot_amount(grp, round_q[1:0]));

	assign fin_a = chain_q[0] + a_q;
	assign fin_b = chain_q[1] + b_q;
	assign fin_c = chain_q[2] + c_q;
	assign fin_d = chain_q[3] + d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			round_q    <= '0;
			count_q    <= '0;
			fill_q     <= '0;
			last_q     <= 1'b0;
			key_mode_q <= 1'b0;
			done_q     <= 1'b0;
			chain_q[0] <= wmd5_pkg::INIT_A;
			chain_q[1] <= wmd5_pkg::INIT_B;
			chain_q[2] <= wmd5_pkg::INIT_C;
			chain_q[3] <= wmd5_pkg::INIT_D;
		end else begin
			done_q <= 1'b0;
			if (cfg_write) begin
				key_mode_q <= pwdata[0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (block_end) begin
							fill_q  <= {1'b0, count_q} + (IW+1)'(1);
							last_q  <= command.last_word;
							count_q <= '0;
							round_q <= '0;
							state_q <= ST_ROUND;
						end else begin
							count_q <= count_q + IW'(1);
						end
					end
				end
				ST_ROUND: begin
					round_q <= round_q + RW'(1);
					if (round_q == RW'(wmd5_pkg::ROUNDS - 1)) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					state_q <= ST_IDLE;
					if (last_q) begin
						done_q     <= 1'b1;
						chain_q[0] <= wmd5_pkg::INIT_A;
						chain_q[1] <= wmd5_pkg::INIT_B;
						chain_q[2] <= wmd5_pkg::INIT_C;
						chain_q[3] <= wmd5_pkg::INIT_D;
					end else begin
						chain_q[0] <= fin_a;
						chain_q[1] <= fin_b;
						chain_q[2] <= fin_c;
						chain_q[3] <= fin_d;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers: word buffer, working variables, digest
	always_ff @(posedge clk) begin
		if (accept) begin
			word_buf_q[count_q] <= command.message_word;
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (state_q == ST_ROUND) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= new_b;
		end
		if (state_q == ST_FINAL) begin
			result_q.digest_low  <= {fin_b, fin_a};
			result_q.digest_high <= {fin_d, fin_c};
		end
	end

`ifndef NO_ASSERTIONS
	a_done_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_FINAL)
		else $error("digest strobe without a final chain add");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("digest strobe longer than one cycle");

	a_last_starts_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command.last_word) |=> (state_q == ST_ROUND && round_q == '0))
		else $error("last word did not start compression");

	a_rounds_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && round_q == RW'(wmd5_pkg::ROUNDS - 1)) |=> state_q == ST_FINAL)
		else $error("round sequence did not end in chain add");

	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> count_q == '0)
		else $error("word count not cleared during compression");
`endif

endmodule
